// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== hdl/bbnfa_pkg.sv =====
// Types, codes and helper functions of the bitmap next-fit block allocator.
// Depends on nothing; used by the interfaces and all RTL modules.
`timescale 1ns / 1ps
`default_nettype none

package bbnfa_pkg;

   // Fixed field widths.
   localparam int BLOCK_W   = 16;
   localparam int WORD_BITS = 64;
   localparam int BIT_IDX_W = 6;

   // Reset value of the first data block register and of the cursor.
   localparam logic [BLOCK_W-1:0] FIRST_DATA_RESET = 16'd1035;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Mask of the bits in a map word whose block number is at or above bound.
   function automatic logic [WORD_BITS-1:0] ge_mask(input logic [10:0] word,
                                                    input logic [16:0] bound);
      logic [10:0] bound_word;
      logic [WORD_BITS-1:0] m;
      bound_word = bound[16:6];
      if (word > bound_word) begin
         m = '1;
      end else if (word < bound_word) begin
         m = '0;
      end else begin
         m = {WORD_BITS{1'b1}} << bound[5:0];
      end
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bbnfa_if.sv =====
// Handshake interfaces for the request and response channels of the allocator.
// Depends on bbnfa_pkg for the operation and status codes.
`timescale 1ns / 1ps
`default_nettype none

interface bbnfa_req_if;
   logic                          valid;
   logic                          ready;
   bbnfa_pkg::op_type             operation;
   logic [bbnfa_pkg::BLOCK_W-1:0] block_number;

   modport source (output valid, output operation, output block_number, input ready);
   modport sink (input valid, input operation, input block_number, output ready);
endinterface

interface bbnfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bbnfa_pkg::BLOCK_W-1:0] granted_block;
   bbnfa_pkg::status_type         status;

   modport source (output valid, output granted_block, output status, input ready);
   modport sink (input valid, input granted_block, input status, output ready);
endinterface

`default_nettype wire

// ===== hdl/bbnfa_map_ram.sv =====
// Usage map storage: one 64-bit word of usage bits per row, one write and one
// registered read port. Depends on bbnfa_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module bbnfa_map_ram #(
   parameter int WORDS = 1024,
   parameter int AW    = 10
) (
   input  wire logic                              clock,
   input  wire logic                              write_enable,
   input  wire logic [AW-1:0]                     write_addr,
   input  wire logic [bbnfa_pkg::WORD_BITS-1:0]   write_data,
   input  wire logic [AW-1:0]                     read_addr,
   output      logic [bbnfa_pkg::WORD_BITS-1:0]   read_data_ff
);

   logic [bbnfa_pkg::WORD_BITS-1:0] mem [WORDS];

   // Write port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      read_data_ff <= mem[read_addr];
   end

endmodule

`default_nettype wire

// ===== hdl/block_bitmap_next_fit_allocator_core.sv =====
// Top level of the bitmap next-fit block allocator: control, cursor, config
// register and response register. Depends on bbnfa_pkg, bbnfa_if, bbnfa_map_ram.
//
//   channel   | direction | payload                          | handshake
//   ----------+-----------+----------------------------------+--------------------
//   req_chan  | in        | operation, block_number          | valid / ready
//   rsp_chan  | out       | granted_block, status            | valid / ready
//   csr_*     | in        | first_data_block (16 bits)       | write enable only
//
// One item is worked on at a time. A free reads one map word; an allocate reads one
// 64-bit word per cycle, set by the single read port, while no earlier result waits,
// and at most WORDS + 1 words, with WORDS = TOP/64 rounded up and TOP the smaller of
// NUM_BLOCKS and 65536. After reset every map word is cleared with no item accepted.
// A waiting result stalls the map reads and the completion of the next item, but
// not its acceptance.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module block_bitmap_next_fit_allocator_core #(
   parameter int NUM_BLOCKS = 65536
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   bbnfa_req_if.sink                          req_chan,
   bbnfa_rsp_if.source                        rsp_chan,
   input  wire logic                          csr_write_enable,
   input  wire logic [bbnfa_pkg::BLOCK_W-1:0] csr_write_data
);

   localparam int TOP   = (NUM_BLOCKS < 65536) ? NUM_BLOCKS : 65536;
   localparam int WORDS = (TOP + 63) / 64;
   localparam int WAW   = $clog2(WORDS);
   localparam logic [16:0]    TOP17     = 17'(TOP);
   localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);

   localparam int WB = bbnfa_pkg::WORD_BITS;

   // Registers.
   bbnfa_pkg::state_type          state_ff, state_in;
   logic [15:0]                   cursor_ff, cursor_in;
   logic [15:0]                   first_data_ff;
   bbnfa_pkg::op_type             op_ff, op_in;
   logic [15:0]                   blk_ff, blk_in;
   logic [WAW-1:0]                word_ff, word_in;
   logic                          wrapped_ff, wrapped_in;
   logic [WAW-1:0]                clr_ff, clr_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   rsp_grant_ff, rsp_grant_in;
   bbnfa_pkg::status_type         rsp_status_ff, rsp_status_in;

   // Map port signals.
   logic                          map_we;
   logic [WAW-1:0]                map_waddr;
   logic [WB-1:0]                 map_wdata;
   logic [WAW-1:0]                map_raddr;
   logic [WB-1:0]                 map_rdata;

   // Region and cursor.
   logic [15:0]                   base;
   logic                          region_ok;
   logic                          cursor_ok;
   logic [15:0]                   cur_eff;
   logic [WAW-1:0]                cur_word;
   logic                          out_free;
   logic                          req_ready;

   // Search of the current word.
   logic [WB-1:0]                 valid_mask;
   logic [WB-1:0]                 cand;
   logic                          hit;
   logic [bbnfa_pkg::BIT_IDX_W-1:0] hit_idx;
   logic [16:0]                   grant17;
   logic [16:0]                   grant_next;
   logic                          blk_in_region;

   bbnfa_map_ram #(
      .WORDS (WORDS),
      .AW    (WAW)
   ) u_map (
      .clock        (clock),
      .write_enable (map_we),
      .write_addr   (map_waddr),
      .write_data   (map_wdata),
      .read_addr    (map_raddr),
      .read_data_ff (map_rdata)
   );

   // Data region bounds; a first data block of zero counts as one.
   always_comb begin
      base          = (first_data_ff == 16'd0) ? 16'd1 : first_data_ff;
      region_ok     = {1'b0, base} < TOP17;
      cursor_ok     = (cursor_ff >= base) && ({1'b0, cursor_ff} < TOP17);
      cur_eff       = cursor_ok ? cursor_ff : base;
      cur_word      = WAW'(cur_eff >> 6);
      blk_in_region = (blk_ff >= base) && ({1'b0, blk_ff} < TOP17);
      out_free      = !rsp_valid_ff || rsp_chan.ready;
   end

   // Free bits of the word just read, within the region and on the right side
   // of the cursor for this pass.
   always_comb begin
      logic [WB-1:0] cur_ge;
      cur_ge     = bbnfa_pkg::ge_mask(11'(word_ff), {1'b0, cur_eff});
      valid_mask = bbnfa_pkg::ge_mask(11'(word_ff), {1'b0, base})
                   & ~bbnfa_pkg::ge_mask(11'(word_ff), TOP17)
                   & (wrapped_ff ? ~cur_ge : cur_ge);
      cand       = ~map_rdata & valid_mask;
      hit        = |cand;
      hit_idx    = '0;
      for (int i = WB - 1; i >= 0; i--) begin
         if (cand[i]) begin
            hit_idx = bbnfa_pkg::BIT_IDX_W'(i);
         end
      end
      grant17    = 17'({word_ff, hit_idx});
      grant_next = grant17 + 17'd1;
   end

   // Next state and map access.
   always_comb begin
      logic [WAW-1:0] start_word;
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      op_in         = op_ff;
      blk_in        = blk_ff;
      word_in       = word_ff;
      wrapped_in    = wrapped_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_status_in = rsp_status_ff;
      map_we        = 1'b0;
      map_waddr     = word_ff;
      map_wdata     = map_rdata;
      map_raddr     = word_ff;
      req_ready     = 1'b0;
      start_word    = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         bbnfa_pkg::ST_CLEAR: begin
            map_we    = 1'b1;
            map_waddr = clr_ff;
            map_wdata = '0;
            if (clr_ff == LAST_WORD) begin
               state_in = bbnfa_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         bbnfa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               // Issue the first read together with the acceptance.
               if (req_chan.operation == bbnfa_pkg::OP_FREE) begin
                  start_word = WAW'(req_chan.block_number >> 6);
               end else begin
                  start_word = cur_word;
               end
               op_in      = req_chan.operation;
               blk_in     = req_chan.block_number;
               word_in    = start_word;
               map_raddr  = start_word;
               wrapped_in = 1'b0;
               state_in   = bbnfa_pkg::ST_SCAN;
            end
         end

         bbnfa_pkg::ST_SCAN: begin
            if (out_free) begin
               if (op_ff == bbnfa_pkg::OP_FREE) begin
                  // Clear the bit of a block inside the region; ignore any other block.
                  rsp_valid_in = 1'b1;
                  rsp_grant_in = '0;
                  state_in     = bbnfa_pkg::ST_IDLE;
                  if (blk_in_region) begin
                     map_we        = 1'b1;
                     map_wdata     = map_rdata & ~({{(WB-1){1'b0}}, 1'b1} << blk_ff[5:0]);
                     rsp_status_in = bbnfa_pkg::STATUS_DONE;
                  end else begin
                     rsp_status_in = bbnfa_pkg::STATUS_IGNORED;
                  end
               end else if (region_ok && hit) begin
                  // Claim the first free block and move the cursor past it.
                  map_we        = 1'b1;
                  map_wdata     = map_rdata | ({{(WB-1){1'b0}}, 1'b1} << hit_idx);
                  rsp_valid_in  = 1'b1;
                  rsp_grant_in  = grant17[15:0];
                  rsp_status_in = bbnfa_pkg::STATUS_DONE;
                  cursor_in     = (grant_next >= TOP17) ? base : grant_next[15:0];
                  state_in      = bbnfa_pkg::ST_IDLE;
               end else if (!region_ok || (wrapped_ff && (word_ff == cur_word))) begin
                  // An empty region, or back at the start word after wrapping: no block is free.
                  rsp_valid_in  = 1'b1;
                  rsp_grant_in  = '0;
                  rsp_status_in = bbnfa_pkg::STATUS_FULL;
                  state_in      = bbnfa_pkg::ST_IDLE;
               end else begin
                  // Step to the next word, wrapping to the first data word.
                  if (word_ff == LAST_WORD) begin
                     word_in    = WAW'(base >> 6);
                     wrapped_in = 1'b1;
                  end else begin
                     word_in = word_ff + 1'b1;
                  end
                  map_raddr = word_in;
               end
            end
         end

         default: begin
            state_in = bbnfa_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bbnfa_pkg::ST_CLEAR;
         cursor_ff     <= bbnfa_pkg::FIRST_DATA_RESET;
         first_data_ff <= bbnfa_pkg::FIRST_DATA_RESET;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            first_data_ff <= csr_write_data;
         end
      end
   end

   // Item and result payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      blk_ff        <= blk_in;
      word_ff       <= word_in;
      wrapped_ff    <= wrapped_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready         = req_ready;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.granted_block = rsp_grant_ff;
   assign rsp_chan.status        = rsp_status_ff;

   // Checks on the control logic.
   `ASSERT_NEVER(a_no_accept_in_clear, clock, reset,
      (state_ff == bbnfa_pkg::ST_CLEAR) && req_chan.ready,
      "item accepted during map clear")
   `ASSERT_SYNC(a_fail_grants_zero, clock, reset,
      (rsp_chan.valid && (rsp_chan.status != bbnfa_pkg::STATUS_DONE))
         |-> (rsp_chan.granted_block == 16'd0),
      "failed request returned a block")
   `ASSERT_SYNC(a_write_when_busy, clock, reset,
      map_we |-> ((state_ff == bbnfa_pkg::ST_CLEAR) || (state_ff == bbnfa_pkg::ST_SCAN)),
      "map written outside clear or scan")
   `ASSERT_SYNC(a_finish_into_free_slot, clock, reset,
      ((state_ff == bbnfa_pkg::ST_SCAN) && (state_in == bbnfa_pkg::ST_IDLE)) |-> out_free,
      "result overwrote a pending result")

endmodule

`default_nettype wire

// ===== tb/bbnfa_checker.sv =====
// Response checker for the bitmap next-fit block allocator.
// Watches the request, response and register ports, predicts each response
// from its own copy of the usage map and cursor, and counts mismatches.
`timescale 1ns / 1ps

module bbnfa_checker
   import bbnfa_pkg::*;
#(
   parameter int NUM_BLOCKS = 65536
) (
   input  wire logic               clock,
   input  wire logic               reset,
   bbnfa_req_if                    req_mon,
   bbnfa_rsp_if                    rsp_mon,
   input  wire logic               csr_write_enable,
   input  wire logic [BLOCK_W-1:0] csr_write_data,
   output int                      fail_count,
   output int                      outstanding
);

   localparam int MAP_SIZE   = 65536;
   localparam int REGION_TOP = (NUM_BLOCKS < MAP_SIZE) ? NUM_BLOCKS : MAP_SIZE;
   localparam int PRINT_CAP  = 40;

   typedef struct {
      logic [BLOCK_W-1:0] granted;
      status_type         status;
   } answer_type;

   // Local copy of the allocator state.
   bit                 block_used [MAP_SIZE];
   logic [BLOCK_W-1:0] first_data;
   logic [BLOCK_W-1:0] cursor;
   answer_type         owed_answers [$];

   // Works out the answer to one request and updates the map and cursor.
   function automatic answer_type next_fit_answer(input op_type op,
                                                  input logic [BLOCK_W-1:0] blk);
      int unsigned base;
      int unsigned count;
      int unsigned start;
      int unsigned b;
      int unsigned i;
      answer_type  ans;
      base        = (first_data == '0) ? 1 : first_data;
      ans.granted = '0;
      if (op == OP_ALLOC) begin
         ans.status = STATUS_FULL;
         if (base < REGION_TOP) begin
            count = REGION_TOP - base;
            start = cursor;
            // A cursor left outside the region restarts the search at its base.
            if (start < base || start >= REGION_TOP) begin
               start = base;
            end
            i = 0;
            while (i < count && ans.status != STATUS_DONE) begin
               b = start + i;
               if (b >= REGION_TOP) begin
                  b = b - count;
               end
               if (!block_used[b]) begin
                  block_used[b] = 1'b1;
                  ans.granted   = b[BLOCK_W-1:0];
                  ans.status    = STATUS_DONE;
                  cursor = (b + 1 >= REGION_TOP) ? base[BLOCK_W-1:0] : BLOCK_W'(b + 1);
               end
               i++;
            end
         end
      end else begin
         if (blk >= base && blk < REGION_TOP) begin
            block_used[blk] = 1'b0;
            ans.status      = STATUS_DONE;
         end else begin
            ans.status = STATUS_IGNORED;
         end
      end
      return ans;
   endfunction

   // Prints one line for a mismatch, up to a cap, and counts it.
   task automatic report_mismatch(input string field, input logic [BLOCK_W-1:0] got,
                                  input logic [BLOCK_W-1:0] want);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
         $display("%0t ns: %s is %0d, predicted %0d", $time, field, got, want);
      end
   endtask

   // All channels are sampled at the rising edge, where the handshakes complete.
   always @(posedge clock) begin : watch
      answer_type want;
      if (reset) begin
         foreach (block_used[i]) begin
            block_used[i] = 1'b0;
         end
         first_data = FIRST_DATA_RESET;
         cursor     = FIRST_DATA_RESET;
         owed_answers.delete();
      end else begin
         // Each response item is held against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_answers.size() == 0) begin
               report_mismatch("response with no request outstanding, granted_block",
                               rsp_mon.granted_block, '0);
            end else begin
               want = owed_answers.pop_front();
               if (rsp_mon.granted_block !== want.granted) begin
                  report_mismatch("granted_block", rsp_mon.granted_block, want.granted);
               end
               if (rsp_mon.status !== want.status) begin
                  report_mismatch("status", BLOCK_W'(rsp_mon.status), BLOCK_W'(want.status));
               end
            end
         end
         if (csr_write_enable) begin
            first_data = csr_write_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            owed_answers.push_back(next_fit_answer(req_mon.operation, req_mon.block_number));
         end
      end
      outstanding <= owed_answers.size();
   end

endmodule

// ===== tb/block_bitmap_next_fit_allocator_core_tb.sv =====
// Top of the allocator testbench: clock, reset, request and register stimulus,
// response back-pressure, watchdog and verdict. Depends on bbnfa_pkg, the
// channel interfaces, the allocator core and bbnfa_checker.
`timescale 1ns / 1ps

module block_bitmap_next_fit_allocator_core_tb;
   import bbnfa_pkg::*;

   localparam int NUM_BLOCKS     = 65536;
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = NUM_BLOCKS / 64 + 4;

   logic               clock;
   logic               reset;
   logic               csr_write_enable;
   logic [BLOCK_W-1:0] csr_write_data;
   int                 fail_count;
   int                 outstanding;

   // Stimulus controls and state shared between the test processes.
   bit                 idling;
   int                 stall_asks;
   logic [BLOCK_W-1:0] region_base;
   logic [BLOCK_W-1:0] granted_pool [$];
   int                 quiet_cycles;

   bbnfa_req_if req_chan ();
   bbnfa_rsp_if rsp_chan ();

   block_bitmap_next_fit_allocator_core #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   bbnfa_checker #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) answer_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Granted blocks are kept so that later frees can hand them back.
   always @(posedge clock) begin
      if (rsp_chan.valid && rsp_chan.ready && rsp_chan.status == STATUS_DONE &&
          rsp_chan.granted_block != '0) begin
         granted_pool.push_back(rsp_chan.granted_block);
      end
   end

   // The watchdog counts cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      quiet_cycles = 0;
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("block_bitmap_next_fit_allocator_core: mismatch");
      $finish;
   end

   // Receiver: random stall bursts while idling is set, plus a long hold-off when one is asked for.
   initial begin : receiver
      int hold_left;
      int gap_left;
      int stall_served;
      hold_left     = 0;
      gap_left      = 0;
      stall_served  = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_asks != stall_served) begin
            stall_served = stall_asks;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idling && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 10) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Offers one request item from a falling edge and returns at the falling
   // edge after it has been taken.
   task automatic send_item(input op_type op, input logic [BLOCK_W-1:0] blk);
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.block_number <= blk;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // When idling is set, sometimes leaves a gap before the next request.
   task automatic sender_pause();
      if (idling && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   // Stops offering and waits until every outstanding response has arrived.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   // Rewrites the first data block while the allocator is idle.
   task automatic write_first_data(input logic [BLOCK_W-1:0] value);
      drain();
      repeat (2) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      region_base = (value == '0) ? 16'd1 : value;
   endtask

   // Random mix: mostly allocations and frees of granted blocks, with frees of
   // arbitrary blocks in and out of the region as noise.
   task automatic random_items(input int n, input int stall_at);
      int                 pick;
      int                 idx;
      logic [BLOCK_W-1:0] blk;
      for (int k = 0; k < n; k++) begin
         if (k == stall_at) begin
            stall_asks <= stall_asks + 1;
         end
         sender_pause();
         pick = $urandom_range(0, 99);
         blk  = 16'($urandom_range(0, 16'hFFFF));
         if (pick < 50 || (pick < 80 && granted_pool.size() == 0)) begin
            send_item(OP_ALLOC, blk);
         end else if (pick < 80) begin
            idx = $urandom_range(0, granted_pool.size() - 1);
            blk = granted_pool[idx];
            granted_pool.delete(idx);
            send_item(OP_FREE, blk);
         end else if (pick < 92) begin
            send_item(OP_FREE, 16'($urandom_range(region_base, 16'hFFFF)));
         end else begin
            send_item(OP_FREE, blk);
         end
      end
   endtask

   // Main sequence of phases.
   initial begin
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_write_data        = '0;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_ALLOC;
      req_chan.block_number = '0;
      idling                = 1'b1;
      stall_asks            = 0;
      region_base           = FIRST_DATA_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset setting: successive grants, double free, frees at both edges
      // of the region and outside it, then next fit past a freed block.
      send_item(OP_ALLOC, 16'h0000);
      send_item(OP_ALLOC, 16'h0000);
      send_item(OP_ALLOC, 16'hFFFF);
      send_item(OP_FREE, 16'd1036);
      send_item(OP_FREE, 16'd1036);
      send_item(OP_FREE, 16'd1034);
      send_item(OP_FREE, 16'h0000);
      send_item(OP_FREE, 16'hFFFF);
      send_item(OP_FREE, 16'd1035);
      send_item(OP_ALLOC, 16'h5555);
      random_items(120, 40);

      // Six-block region: fill it, hit the full case, wrap back to a freed block.
      write_first_data(16'd65530);
      repeat (7) send_item(OP_ALLOC, 16'hAAAA);
      send_item(OP_FREE, 16'd65533);
      send_item(OP_ALLOC, 16'h0000);
      random_items(80, -1);

      // Single-block region at the top of the map.
      write_first_data(16'hFFFF);
      send_item(OP_ALLOC, 16'h0000);
      send_item(OP_ALLOC, 16'h0000);
      send_item(OP_FREE, 16'hFFFF);
      random_items(30, -1);

      // A first data block of zero behaves as one, so block zero stays reserved.
      write_first_data(16'h0000);
      send_item(OP_FREE, 16'h0000);
      send_item(OP_ALLOC, 16'h0000);
      random_items(80, -1);

      // Widest region, first without and then with idling.
      write_first_data(16'h0001);
      idling <= 1'b0;
      random_items(40, -1);
      idling <= 1'b1;
      random_items(40, -1);

      // Random settings, half of them small regions near the top.
      for (int p = 0; p < 3; p++) begin
         if ($urandom_range(0, 1) == 1) begin
            write_first_data(16'($urandom_range(65400, 65535)));
         end else begin
            write_first_data(16'($urandom_range(0, 65535)));
         end
         random_items(50, -1);
      end

      // Closing stretch back at the reset setting, with no idling.
      write_first_data(FIRST_DATA_RESET);
      idling <= 1'b0;
      random_items(80, -1);

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("block_bitmap_next_fit_allocator_core: match");
      end else begin
         $display("block_bitmap_next_fit_allocator_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bbnfa_pkg.sv
hdl/bbnfa_if.sv
hdl/bbnfa_map_ram.sv
hdl/block_bitmap_next_fit_allocator_core.sv
tb/bbnfa_checker.sv
tb/block_bitmap_next_fit_allocator_core_tb.sv
